### sv/wall_clock_anchor_keeper_core_defines.svh
// Assertion macros shared by the clock anchor keeper RTL.
`ifndef WALL_CLOCK_ANCHOR_KEEPER_CORE_DEFINES_SVH
`define WALL_CLOCK_ANCHOR_KEEPER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WCAK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wcak: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WCAK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wcak: next-cycle check failed");

`endif

### sv/wcak_pkg.sv
package wcak_pkg;

    localparam int MS_W      = 32;
    localparam int EPOCH_W   = 32;
    localparam int INTERVAL_W = 32;
    localparam int SEC_CNT_W = 23;   // (2^32-1)/1000 fits in 23 bits
    localparam int MCOUNT_W  = 27;   // (2^32-1)/60
    localparam int HCOUNT_W  = 21;   // (2^32-1)/3600
    localparam int DCOUNT_W  = 16;   // (2^32-1)/86400
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int WDAY_W    = 3;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    // Action codes of an input word.
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_BEGIN = 1'b1;

    localparam logic [INTERVAL_W-1:0] ATTEMPT_INTERVAL_RESET = 32'd5000;
    localparam logic [INTERVAL_W-1:0] RESYNC_INTERVAL_RESET  = 32'd3600000;

    localparam logic [31:0] SEC_PER_MIN    = 32'd60;
    localparam logic [31:0] HOURS_PER_DAY  = 32'd24;
    localparam logic [31:0] WEEKDAY_OFFSET = 32'd4;
    localparam logic [3:0]  DAYS_PER_WEEK  = 4'd7;

    // Reciprocal constants: floor(x/d) == (x * MAGIC) >> SHIFT for every 32-bit x.
    localparam logic [31:0] MAGIC_DIV1000 = 32'h10624DD3;
    localparam int          SHIFT_DIV1000 = 38;
    localparam logic [31:0] MAGIC_DIV60   = 32'h88888889;
    localparam int          SHIFT_DIV60   = 37;
    localparam logic [31:0] MAGIC_DIV3    = 32'hAAAAAAAB;
    localparam int          SHIFT_DIV3    = 33;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ATTEMPT_INTERVAL = 1'b0,
        REG_RESYNC_INTERVAL  = 1'b1
    } cfg_index_t;

    // Stage 1: attempt decision made, anchor already updated.
    typedef struct packed {
        logic               attempt;
        logic               synced;
        logic [MS_W-1:0]    now_ms;
        logic [MS_W-1:0]    anchor_ms;
        logic [EPOCH_W-1:0] anchor_epoch;
    } stage1_t;

    // Stage 2: whole seconds since the anchor.
    typedef struct packed {
        logic                 attempt;
        logic                 synced;
        logic [EPOCH_W-1:0]   anchor_epoch;
        logic [SEC_CNT_W-1:0] sec_count;
    } stage2_t;

    // Stage 3: free-run epoch.
    typedef struct packed {
        logic               attempt;
        logic               synced;
        logic [EPOCH_W-1:0] epoch;
    } stage3_t;

    // Stage 4: minute count.
    typedef struct packed {
        logic                attempt;
        logic                synced;
        logic [EPOCH_W-1:0]  epoch;
        logic [MCOUNT_W-1:0] mcount;
    } stage4_t;

    // Stage 5: seconds field, hour count, minute roll.
    typedef struct packed {
        logic                attempt;
        logic                synced;
        logic                rolled;
        logic [EPOCH_W-1:0]  epoch;
        logic [SECOND_W-1:0] second;
        logic [MCOUNT_W-1:0] mcount;
        logic [HCOUNT_W-1:0] hcount;
    } stage5_t;

    // Stage 6: minute field, day count.
    typedef struct packed {
        logic                attempt;
        logic                synced;
        logic                rolled;
        logic [EPOCH_W-1:0]  epoch;
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HCOUNT_W-1:0] hcount;
        logic [DCOUNT_W-1:0] dcount;
    } stage6_t;

    // Stage 7: the result word.
    typedef struct packed {
        logic                time_valid;
        logic [EPOCH_W-1:0]  epoch_seconds;
        logic [HOUR_W-1:0]   hour_of_day;
        logic [MINUTE_W-1:0] minute_of_hour;
        logic [SECOND_W-1:0] second_of_minute;
        logic [WDAY_W-1:0]   day_of_week;
        logic                minute_rolled;
        logic                attempt_made;
    } result_t;

endpackage

### sv/wcak_if.sv
interface wcak_item_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [wcak_pkg::MS_W-1:0]         now_ms;
    logic                              source_ready;
    logic [wcak_pkg::EPOCH_W-1:0]      source_epoch;

    modport source (output valid, output action, output now_ms, output source_ready,
                    output source_epoch, input ready);
    modport sink   (input valid, input action, input now_ms, input source_ready,
                    input source_epoch, output ready);
endinterface

interface wcak_result_if;
    logic                              valid;
    logic                              ready;
    logic                              time_valid;
    logic [wcak_pkg::EPOCH_W-1:0]      epoch_seconds;
    logic [wcak_pkg::HOUR_W-1:0]       hour_of_day;
    logic [wcak_pkg::MINUTE_W-1:0]     minute_of_hour;
    logic [wcak_pkg::SECOND_W-1:0]     second_of_minute;
    logic [wcak_pkg::WDAY_W-1:0]       day_of_week;
    logic                              minute_rolled;
    logic                              attempt_made;

    modport source (output valid, output time_valid, output epoch_seconds,
                    output hour_of_day, output minute_of_hour, output second_of_minute,
                    output day_of_week, output minute_rolled, output attempt_made,
                    input ready);
    modport sink   (input valid, input time_valid, input epoch_seconds,
                    input hour_of_day, input minute_of_hour, input second_of_minute,
                    input day_of_week, input minute_rolled, input attempt_made,
                    output ready);
endinterface

### sv/wall_clock_anchor_keeper_core.sv
// Channel   Direction  Word carried
// --------  ---------  ------------------------------------------------------------
// item      in         action, now_ms, source_ready, source_epoch
// result    out        time_valid, epoch_seconds, h/m/s, day_of_week, rolled, attempt
// write_*   in         interval register writes (index 0 attempt, 1 resync)
//
// One word per cycle sustained while the result side is ready; seven register stages.
// A word moves through the stage registers s1 to s7 in order and is offered on the
// result channel from s7, the result register.
// The attempt/anchor loop closes in stage 1 with one 32-bit subtract and compare.
// Stages stall individually: a full stage with an empty stage after it keeps moving, so
// input is refused only once every stage holds a word behind a stalled result.
// rst_n clears valids and the clock state at once; no sweep.
`include "wall_clock_anchor_keeper_core_defines.svh"

module wall_clock_anchor_keeper_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    wcak_item_if.sink                             item,
    wcak_result_if.source                         result,
    input  logic                                  write_en,
    input  logic [wcak_pkg::CFG_INDEX_W-1:0]      write_index,
    input  logic [wcak_pkg::CFG_DATA_W-1:0]       write_data
);
    import wcak_pkg::*;

    localparam int NUM_STAGES = 7;

    // Configuration.
    logic [INTERVAL_W-1:0] attempt_interval_reg;
    logic [INTERVAL_W-1:0] resync_interval_reg;

    // Clock state.
    logic [MS_W-1:0]     last_attempt_reg, last_attempt_next;
    logic [EPOCH_W-1:0]  anchor_epoch_reg, anchor_epoch_next;
    logic [MS_W-1:0]     anchor_ms_reg, anchor_ms_next;
    logic                synced_reg, synced_next;
    logic                minute_seen_reg;
    logic [MCOUNT_W-1:0] last_minute_reg;

    // Pipeline.
    logic [NUM_STAGES:1] valid_reg;
    logic [NUM_STAGES:1] advance;
    stage1_t s1_reg, s1_next;
    stage2_t s2_reg, s2_next;
    stage3_t s3_reg, s3_next;
    stage4_t s4_reg, s4_next;
    stage5_t s5_reg, s5_next;
    stage6_t s6_reg, s6_next;
    result_t s7_reg, s7_next;

    logic                  accept;
    logic                  attempt;
    logic [INTERVAL_W-1:0] interval;
    logic [MS_W-1:0]       since_attempt;
    logic [MS_W-1:0]       elapsed_ms;
    logic [63:0]           prod_ms;
    logic [63:0]           prod_min;
    logic [63:0]           prod_hour;
    logic [63:0]           prod_day;
    logic [31:0]           sec_rem;
    logic [31:0]           min_rem;
    logic [31:0]           hour_rem;
    logic                  minute_update;
    logic [DCOUNT_W:0]     wday_sum;
    logic [17:0]           wday_pad;
    logic [5:0]            fold1;
    logic [3:0]            fold2;
    logic [WDAY_W-1:0]     wday;

    // Terms for the checks.
    logic                  unsynced_word;
    logic                  synced_word;
    logic                  zeroed_fields;
    logic                  fields_ok;

    // ---------------------------------------------------------------------
    // Handshake: a stage takes a new word when empty or when it empties now.
    // ---------------------------------------------------------------------
    always_comb
    begin
        advance[NUM_STAGES] = !valid_reg[NUM_STAGES] || result.ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            advance[k] = !valid_reg[k] || advance[k+1];
        end
    end

    assign item.ready = advance[1];
    assign accept     = item.valid && advance[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (advance[1])
            begin
                valid_reg[1] <= item.valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++)
            begin
                if (advance[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Configuration writes: ignore nothing, every index maps to a register.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attempt_interval_reg <= ATTEMPT_INTERVAL_RESET;
            resync_interval_reg  <= RESYNC_INTERVAL_RESET;
        end
        else if (write_en)
        begin
            case (cfg_index_t'(write_index))
                REG_ATTEMPT_INTERVAL: attempt_interval_reg <= write_data[INTERVAL_W-1:0];
                REG_RESYNC_INTERVAL:  resync_interval_reg  <= write_data[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: decide on an attempt and re-anchor. This loop feeds back into
    // the next word, so it stays one subtract and one compare.
    // ---------------------------------------------------------------------
    always_comb
    begin
        interval      = synced_reg ? resync_interval_reg : attempt_interval_reg;
        since_attempt = item.now_ms - last_attempt_reg;
        attempt       = (item.action == ACT_BEGIN) || (since_attempt >= interval);

        last_attempt_next = last_attempt_reg;
        anchor_epoch_next = anchor_epoch_reg;
        anchor_ms_next    = anchor_ms_reg;
        synced_next       = synced_reg;
        if (attempt)
        begin
            last_attempt_next = item.now_ms;
            if (item.source_ready)
            begin
                anchor_epoch_next = item.source_epoch;
                anchor_ms_next    = item.now_ms;
                synced_next       = 1'b1;
            end
        end

        s1_next.attempt      = attempt;
        s1_next.synced       = synced_next;
        s1_next.now_ms       = item.now_ms;
        s1_next.anchor_ms    = anchor_ms_next;
        s1_next.anchor_epoch = anchor_epoch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_attempt_reg <= '0;
            anchor_epoch_reg <= '0;
            anchor_ms_reg    <= '0;
            synced_reg       <= 1'b0;
        end
        else if (accept)
        begin
            last_attempt_reg <= last_attempt_next;
            anchor_epoch_reg <= anchor_epoch_next;
            anchor_ms_reg    <= anchor_ms_next;
            synced_reg       <= synced_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: elapsed milliseconds divided by 1000 through a reciprocal.
    // ---------------------------------------------------------------------
    always_comb
    begin
        elapsed_ms = s1_reg.now_ms - s1_reg.anchor_ms;
        prod_ms    = {32'd0, elapsed_ms} * {32'd0, MAGIC_DIV1000};

        s2_next.attempt      = s1_reg.attempt;
        s2_next.synced       = s1_reg.synced;
        s2_next.anchor_epoch = s1_reg.anchor_epoch;
        s2_next.sec_count    = prod_ms[SHIFT_DIV1000 +: SEC_CNT_W];
    end

    // Stage 3: free-run epoch, wrapping modulo 2^32.
    always_comb
    begin
        s3_next.attempt = s2_reg.attempt;
        s3_next.synced  = s2_reg.synced;
        s3_next.epoch   = s2_reg.anchor_epoch + EPOCH_W'(s2_reg.sec_count);
    end

    // Stage 4: minute count = epoch / 60.
    always_comb
    begin
        prod_min = {32'd0, s3_reg.epoch} * {32'd0, MAGIC_DIV60};

        s4_next.attempt = s3_reg.attempt;
        s4_next.synced  = s3_reg.synced;
        s4_next.epoch   = s3_reg.epoch;
        s4_next.mcount  = prod_min[SHIFT_DIV60 +: MCOUNT_W];
    end

    // Stage 5: seconds field, hour count, and the minute roll against the
    // minute of the last valid word (that word passed this stage just before).
    always_comb
    begin
        sec_rem   = s4_reg.epoch - (32'(s4_reg.mcount) * SEC_PER_MIN);
        prod_hour = {37'd0, s4_reg.mcount} * {32'd0, MAGIC_DIV60};
        minute_update = s4_reg.synced
            && (!minute_seen_reg || (s4_reg.mcount != last_minute_reg));

        s5_next.attempt = s4_reg.attempt;
        s5_next.synced  = s4_reg.synced;
        s5_next.rolled  = minute_update;
        s5_next.epoch   = s4_reg.epoch;
        s5_next.second  = sec_rem[SECOND_W-1:0];
        s5_next.mcount  = s4_reg.mcount;
        s5_next.hcount  = prod_hour[SHIFT_DIV60 +: HCOUNT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minute_seen_reg <= 1'b0;
            last_minute_reg <= '0;
        end
        else if (advance[5] && valid_reg[4] && minute_update)
        begin
            minute_seen_reg <= 1'b1;
            last_minute_reg <= s4_reg.mcount;
        end
    end

    // Stage 6: minute field, day count = (hours / 8) / 3.
    always_comb
    begin
        min_rem  = 32'(s5_reg.mcount) - (32'(s5_reg.hcount) * SEC_PER_MIN);
        prod_day = {46'd0, s5_reg.hcount[HCOUNT_W-1:3]} * {32'd0, MAGIC_DIV3};

        s6_next.attempt = s5_reg.attempt;
        s6_next.synced  = s5_reg.synced;
        s6_next.rolled  = s5_reg.rolled;
        s6_next.epoch   = s5_reg.epoch;
        s6_next.second  = s5_reg.second;
        s6_next.minute  = min_rem[MINUTE_W-1:0];
        s6_next.hcount  = s5_reg.hcount;
        s6_next.dcount  = prod_day[SHIFT_DIV3 +: DCOUNT_W];
    end

    // Stage 7: hour field, weekday by folding octal digits (8 mod 7 is 1),
    // then zero everything but the attempt flag while unsynced.
    always_comb
    begin
        hour_rem = 32'(s6_reg.hcount) - (32'(s6_reg.dcount) * HOURS_PER_DAY);
        wday_sum = {1'b0, s6_reg.dcount} + WEEKDAY_OFFSET[DCOUNT_W:0];
        wday_pad = 18'(wday_sum);
        fold1 = 6'(wday_pad[2:0]) + 6'(wday_pad[5:3]) + 6'(wday_pad[8:6])
              + 6'(wday_pad[11:9]) + 6'(wday_pad[14:12]) + 6'(wday_pad[17:15]);
        fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
        if (fold2 >= DAYS_PER_WEEK)
        begin
            wday = WDAY_W'(fold2 - DAYS_PER_WEEK);
        end
        else
        begin
            wday = fold2[WDAY_W-1:0];
        end

        s7_next.time_valid       = s6_reg.synced;
        s7_next.attempt_made     = s6_reg.attempt;
        s7_next.epoch_seconds    = s6_reg.synced ? s6_reg.epoch : '0;
        s7_next.hour_of_day      = s6_reg.synced ? hour_rem[HOUR_W-1:0] : '0;
        s7_next.minute_of_hour   = s6_reg.synced ? s6_reg.minute : '0;
        s7_next.second_of_minute = s6_reg.synced ? s6_reg.second : '0;
        s7_next.day_of_week      = s6_reg.synced ? wday : '0;
        s7_next.minute_rolled    = s6_reg.synced && s6_reg.rolled;
    end

    // Pipeline payload: hold a stage while it is stalled, no reset needed.
    always_ff @(posedge clk)
    begin
        if (advance[1]) s1_reg <= s1_next;
        if (advance[2]) s2_reg <= s2_next;
        if (advance[3]) s3_reg <= s3_next;
        if (advance[4]) s4_reg <= s4_next;
        if (advance[5]) s5_reg <= s5_next;
        if (advance[6]) s6_reg <= s6_next;
        if (advance[7]) s7_reg <= s7_next;
    end

    // Result register drives the output word.
    assign result.valid            = valid_reg[NUM_STAGES];
    assign result.time_valid       = s7_reg.time_valid;
    assign result.epoch_seconds    = s7_reg.epoch_seconds;
    assign result.hour_of_day      = s7_reg.hour_of_day;
    assign result.minute_of_hour   = s7_reg.minute_of_hour;
    assign result.second_of_minute = s7_reg.second_of_minute;
    assign result.day_of_week      = s7_reg.day_of_week;
    assign result.minute_rolled    = s7_reg.minute_rolled;
    assign result.attempt_made     = s7_reg.attempt_made;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    assign unsynced_word = result.valid && !result.time_valid;
    assign synced_word   = result.valid && result.time_valid;
    assign zeroed_fields = (result.epoch_seconds == '0) && !result.minute_rolled;
    assign fields_ok     = (result.hour_of_day < 5'd24) && (result.minute_of_hour < 6'd60)
                        && (result.second_of_minute < 6'd60) && (result.day_of_week < 3'd7);

    `WCAK_ASSERT_NEXT(a_begin_attempts, clk, rst_n, accept && (item.action == ACT_BEGIN), s1_reg.attempt)
    `WCAK_ASSERT_NOW(a_synced_sticky, clk, rst_n, 1'b1, !$fell(synced_reg))
    `WCAK_ASSERT_NOW(a_unsynced_zero, clk, rst_n, unsynced_word, zeroed_fields)
    `WCAK_ASSERT_NOW(a_fields_in_range, clk, rst_n, synced_word, fields_ok && minute_seen_reg)

endmodule

### tb/testbench.sv
module testbench;
    import wcak_pkg::*;

    // Time arithmetic.
    localparam logic [31:0] MS_IN_SEC       = 32'd1000;
    localparam logic [31:0] SEC_IN_MIN      = 32'd60;
    localparam logic [31:0] SEC_IN_HOUR     = 32'd3600;
    localparam logic [31:0] HOURS_IN_DAY    = 32'd24;
    localparam logic [31:0] SEC_IN_DAY      = 32'd86400;
    localparam logic [31:0] THURSDAY_OFFSET = 32'd4;
    localparam logic [31:0] WEEK_DAYS       = 32'd7;

    // Interval values used by the tests.
    localparam logic [31:0] ATTEMPT_DEFAULT = 32'd5000;
    localparam logic [31:0] RESYNC_DEFAULT  = 32'd3600000;
    localparam logic [31:0] INTERVAL_MAX    = 32'hFFFF_FFFF;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PRINT_CAP     = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 200;

    logic clk;
    logic rst_n;
    logic write_en;
    logic [CFG_INDEX_W-1:0] write_index;
    logic [CFG_DATA_W-1:0]  write_data;

    wcak_item_if   item_ch();
    wcak_result_if result_ch();

    wall_clock_anchor_keeper_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data)
    );

    // Clock: period of 4 time units.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the interval registers and of the
    // anchor keeper's clock state.
    // ------------------------------------------------------------------
    logic [31:0] attempt_ivl    = ATTEMPT_DEFAULT;
    logic [31:0] resync_ivl     = RESYNC_DEFAULT;
    logic [31:0] last_try_ms    = '0;
    logic [31:0] anchor_epoch_q = '0;
    logic [31:0] anchor_ms_q    = '0;
    logic        is_synced      = 1'b0;
    logic        minute_seen_q  = 1'b0;
    logic [MCOUNT_W-1:0] last_minute_q = '0;

    // Words expected on the result channel, oldest first.
    result_t pending_clock_words[$];

    // Scoreboard and coverage counters.
    int mismatches      = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int attempts_seen   = 0;
    int anchored_seen   = 0;
    int rolls_seen      = 0;
    int input_stalls    = 0;
    int cycle_count     = 0;

    // Sender pacing: bursts of random length separated by random gaps.
    int burst_left   = 0;
    bit gaps_enabled = 1'b1;

    // Long receiver hold-off: bump hold_requests, the stall process serves it.
    int hold_requests = 0;
    int hold_length   = 0;

    // Well-formed traffic: a monotonic ms counter and a source that tracks it.
    logic [31:0] track_now  = '0;
    logic [31:0] epoch_base = '0;
    logic        source_up  = 1'b1;

    // Work out the result word for one accepted input word and advance state.
    function automatic result_t predict_clock_word(input logic act, input logic [31:0] now,
                                                   input logic rdy, input logic [31:0] src);
        result_t     w;
        logic        tried;
        logic [31:0] span;
        logic [31:0] secs;
        logic [31:0] part;
        logic [MCOUNT_W-1:0] mcount;
        w = '0;
        if (act == ACT_BEGIN)
        begin
            tried = 1'b1;
        end
        else
        begin
            span  = now - last_try_ms;
            tried = span >= (is_synced ? resync_ivl : attempt_ivl);
        end
        if (tried)
        begin
            last_try_ms = now;
            if (rdy)
            begin
                anchor_epoch_q = src;
                anchor_ms_q    = now;
                is_synced      = 1'b1;
            end
        end
        if (is_synced)
        begin
            span = now - anchor_ms_q;
            secs = anchor_epoch_q + span / MS_IN_SEC;
            w.epoch_seconds    = secs;
            part               = secs % SEC_IN_MIN;
            w.second_of_minute = part[SECOND_W-1:0];
            part               = (secs / SEC_IN_MIN) % SEC_IN_MIN;
            w.minute_of_hour   = part[MINUTE_W-1:0];
            part               = (secs / SEC_IN_HOUR) % HOURS_IN_DAY;
            w.hour_of_day      = part[HOUR_W-1:0];
            part               = ((secs / SEC_IN_DAY) + THURSDAY_OFFSET) % WEEK_DAYS;
            w.day_of_week      = part[WDAY_W-1:0];
            part               = secs / SEC_IN_MIN;
            mcount             = part[MCOUNT_W-1:0];
            // Flag the first valid minute and every change of minute.
            if (!minute_seen_q || mcount != last_minute_q)
            begin
                minute_seen_q   = 1'b1;
                last_minute_q   = mcount;
                w.minute_rolled = 1'b1;
            end
        end
        w.time_valid   = is_synced;
        w.attempt_made = tried;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] result word %0d: %s got 0x%0h, want 0x%0h",
                     $time, results_checked, what, got, want);
    endtask

    // Offer one word and hold it until accepted; pace with bursts and gaps.
    task automatic send_word(input logic act, input logic [31:0] now,
                             input logic rdy, input logic [31:0] src);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_enabled && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 9);
        end
        burst_left--;
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.action       <= act;
        item_ch.now_ms       <= now;
        item_ch.source_ready <= rdy;
        item_ch.source_epoch <= src;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        pending_clock_words.push_back(predict_clock_word(act, now, rdy, src));
        words_sent++;
    endtask

    // Drop valid and hold off until every expected word has come back.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_clock_words.size() != 0)
            @(posedge clk);
    endtask

    // Write one interval register; call only while the block is drained.
    task automatic write_interval(input cfg_index_t idx, input logic [31:0] value);
        write_en    <= 1'b1;
        write_index <= idx;
        write_data  <= value;
        @(posedge clk);
        write_en <= 1'b0;
        if (idx == REG_ATTEMPT_INTERVAL)
            attempt_ivl = value;
        else
            resync_ivl = value;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_interval();
        case ($urandom_range(0, 5))
            0:       return RESYNC_DEFAULT;
            1:       return $urandom_range(1, 50);
            2:       return $urandom_range(500, 20000);
            3:       return '0;
            4:       return INTERVAL_MAX;
            default: return $urandom_range(100000, 4000000);
        endcase
    endfunction

    // Mostly a well-behaved source riding a rising ms counter, some noise.
    task automatic run_clock_traffic(input int count);
        logic [31:0] step;
        logic [31:0] gate;
        logic [31:0] epoch;
        logic        act;
        logic        rdy;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                act = 1'($urandom_range(0, 1));
                rdy = 1'($urandom_range(0, 1));
                send_word(act, $urandom, rdy, $urandom);
            end
            else
            begin
                gate = is_synced ? resync_ivl : attempt_ivl;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: step = $urandom_range(1, 1000);
                    4, 5:       step = $urandom_range(1000, 70000);
                    6, 7:       step = gate + $urandom_range(0, 2) - 1;
                    8:          step = $urandom_range(0, gate);
                    default:    step = $urandom;
                endcase
                track_now = track_now + step;
                if ($urandom_range(0, 39) == 0)
                    source_up = ~source_up;
                epoch = epoch_base + track_now / MS_IN_SEC;
                if ($urandom_range(0, 7) == 0)
                    epoch = epoch + $urandom_range(0, 2);
                act = ($urandom_range(0, 24) == 0) ? ACT_BEGIN : ACT_TICK;
                send_word(act, track_now, source_up, epoch);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Retry spacing before the first anchor; no attempt finds the source ready.
    task automatic test_unsynced_retry();
        // Ready source but interval not reached: ignore it.
        send_word(ACT_TICK, 32'd0, 1'b1, 32'd1234);
        send_word(ACT_TICK, 32'd4999, 1'b0, 32'd0);
        send_word(ACT_TICK, 32'd5000, 1'b0, INTERVAL_MAX);
        wait_drained();
        // Zero interval: every tick attempts, even with no time passed.
        write_interval(REG_ATTEMPT_INTERVAL, '0);
        send_word(ACT_TICK, 32'd5000, 1'b0, 32'd7);
        send_word(ACT_TICK, 32'd3, 1'b0, 32'd7);
        wait_drained();
        write_interval(REG_ATTEMPT_INTERVAL, 32'd1);
        send_word(ACT_TICK, 32'd3, 1'b0, 32'd0);
        send_word(ACT_TICK, 32'd4, 1'b0, 32'd0);
        wait_drained();
        // Widest interval: only a full wrap minus one trips it.
        write_interval(REG_ATTEMPT_INTERVAL, INTERVAL_MAX);
        send_word(ACT_TICK, 32'd2, 1'b0, 32'd0);
        send_word(ACT_TICK, 32'd3, 1'b0, 32'd0);
        send_word(ACT_BEGIN, 32'h1234_5678, 1'b0, 32'd0);
        wait_drained();
        write_interval(REG_ATTEMPT_INTERVAL, ATTEMPT_DEFAULT);
    endtask

    // First anchor, field extremes, weekday edges and re-anchor corners.
    task automatic test_anchor_and_fields();
        send_word(ACT_BEGIN, 32'd12000, 1'b1, 32'd0);
        send_word(ACT_TICK, 32'd12999, 1'b1, 32'd99);
        send_word(ACT_TICK, 32'd13000, 1'b1, 32'd99);
        send_word(ACT_TICK, 32'd72000, 1'b1, 32'd99);
        // Exactly one resync interval later, source down: anchor stays.
        send_word(ACT_TICK, 32'd3612000, 1'b0, 32'd5);
        send_word(ACT_TICK, 32'd3612001, 1'b1, 32'd5);
        // Largest epoch, then let the ms counter and the epoch both wrap.
        send_word(ACT_BEGIN, INTERVAL_MAX, 1'b1, INTERVAL_MAX);
        send_word(ACT_TICK, 32'd999, 1'b1, 32'd0);
        send_word(ACT_TICK, 32'd3599998, 1'b1, 32'd0);
        send_word(ACT_TICK, 32'd3599999, 1'b1, 32'd86399);
        // Sunday, Saturday and alternating bit patterns.
        send_word(ACT_BEGIN, 32'd3600999, 1'b1, 32'd259200);
        send_word(ACT_BEGIN, 32'd3600999, 1'b1, 32'd172800);
        send_word(ACT_BEGIN, 32'd3600999, 1'b1, 32'hAAAA_AAAA);
        send_word(ACT_BEGIN, 32'd3600999, 1'b1, 32'h5555_5555);
        // Re-anchor inside the same minute: no roll.
        send_word(ACT_BEGIN, 32'd3600999, 1'b1, 32'h5555_5556);
        send_word(ACT_BEGIN, 32'd3605999, 1'b0, 32'd0);
        send_word(ACT_BEGIN, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF);
        wait_drained();
    endtask

    // Resync interval at zero, one and its widest value while synced.
    task automatic test_resync_extremes();
        logic [31:0] base;
        write_interval(REG_RESYNC_INTERVAL, '0);
        base = last_try_ms;
        send_word(ACT_TICK, base, 1'b1, 32'd1000);
        send_word(ACT_TICK, base, 1'b0, 32'd2000);
        wait_drained();
        write_interval(REG_RESYNC_INTERVAL, 32'd1);
        send_word(ACT_TICK, base, 1'b1, 32'd3000);
        send_word(ACT_TICK, base + 32'd1, 1'b1, 32'd4000);
        wait_drained();
        write_interval(REG_RESYNC_INTERVAL, INTERVAL_MAX);
        base = last_try_ms;
        send_word(ACT_TICK, base + 32'hFFFF_FFFE, 1'b1, 32'd5000);
        send_word(ACT_TICK, base + INTERVAL_MAX, 1'b1, 32'd6000);
        wait_drained();
    endtask

    // Hold the result side for a long stretch while words keep coming.
    task automatic test_backpressure();
        write_interval(REG_RESYNC_INTERVAL, 32'd2000);
        track_now  = last_try_ms;
        epoch_base = $urandom;
        source_up  = 1'b1;
        gaps_enabled = 1'b0;
        hold_length  = 150;
        hold_requests++;
        run_clock_traffic(60);
        gaps_enabled = 1'b1;
        // Pause the sender until every word is back, then resume.
        wait_drained();
        run_clock_traffic(30);
        wait_drained();
    endtask

    // Random traffic in phases, each with its own pair of intervals.
    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            write_interval(REG_ATTEMPT_INTERVAL, pick_interval());
            write_interval(REG_RESYNC_INTERVAL, pick_interval());
            epoch_base = (p == 1) ? 32'hFFFF_0000 : $urandom;
            source_up  = 1'b1;
            run_clock_traffic(PHASE_WORDS);
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Result side: stall on a pattern of its own, serve long hold-offs.
    // ------------------------------------------------------------------
    initial
    begin : result_stall_driver
        int mode;
        int mode_left;
        int hold_left;
        int served;
        int tick;
        int run_left;
        logic run_on;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        served    = 0;
        tick      = 0;
        run_left  = 0;
        run_on    = 1'b1;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (served != hold_requests)
            begin
                served    = hold_requests;
                hold_left = hold_length;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 4);
                mode_left = $urandom_range(40, 300);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= 1'($urandom_range(0, 1));
                    2: result_ch.ready <= (tick % 3) != 0;
                    3: result_ch.ready <= $urandom_range(0, 7) != 0;
                    default:
                    begin
                        // Alternate runs of stall and flow.
                        if (run_left == 0)
                        begin
                            run_on   = ~run_on;
                            run_left = run_on ? $urandom_range(1, 6) : $urandom_range(1, 20);
                        end
                        run_left--;
                        result_ch.ready <= run_on;
                    end
                endcase
            end
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge clk)
    begin : result_checker
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_clock_words.size() == 0)
            begin
                report_mismatch("word with none expected", result_ch.epoch_seconds, '0);
            end
            else
            begin
                want = pending_clock_words.pop_front();
                if (result_ch.time_valid !== want.time_valid)
                    report_mismatch("time_valid", 32'(result_ch.time_valid),
                                    32'(want.time_valid));
                if (result_ch.epoch_seconds !== want.epoch_seconds)
                    report_mismatch("epoch_seconds", result_ch.epoch_seconds,
                                    want.epoch_seconds);
                if (result_ch.hour_of_day !== want.hour_of_day)
                    report_mismatch("hour_of_day", 32'(result_ch.hour_of_day),
                                    32'(want.hour_of_day));
                if (result_ch.minute_of_hour !== want.minute_of_hour)
                    report_mismatch("minute_of_hour", 32'(result_ch.minute_of_hour),
                                    32'(want.minute_of_hour));
                if (result_ch.second_of_minute !== want.second_of_minute)
                    report_mismatch("second_of_minute", 32'(result_ch.second_of_minute),
                                    32'(want.second_of_minute));
                if (result_ch.day_of_week !== want.day_of_week)
                    report_mismatch("day_of_week", 32'(result_ch.day_of_week),
                                    32'(want.day_of_week));
                if (result_ch.minute_rolled !== want.minute_rolled)
                    report_mismatch("minute_rolled", 32'(result_ch.minute_rolled),
                                    32'(want.minute_rolled));
                if (result_ch.attempt_made !== want.attempt_made)
                    report_mismatch("attempt_made", 32'(result_ch.attempt_made),
                                    32'(want.attempt_made));
                attempts_seen += int'(want.attempt_made);
                anchored_seen += int'(want.time_valid);
                rolls_seen    += int'(want.minute_rolled);
            end
            results_checked++;
        end
    end

    // Count cycles where the block refused an offered word.
    always @(posedge clk)
    begin
        if (rst_n && item_ch.valid && !item_ch.ready)
            input_stalls++;
    end

    // Watchdog: end a hung run.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d words outstanding",
                 cycle_count, pending_clock_words.size());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Drive every input to a known value before the first edge.
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.action       = ACT_TICK;
        item_ch.now_ms       = '0;
        item_ch.source_ready = 1'b0;
        item_ch.source_epoch = '0;
        write_en             = 1'b0;
        write_index          = REG_ATTEMPT_INTERVAL;
        write_data           = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unsynced_retry();
        test_anchor_and_fields();
        test_resync_extremes();
        test_backpressure();
        test_random_traffic();

        // Let the pipeline settle before the verdict.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d of %0d words: %0d attempts, %0d anchored, %0d minute rolls",
                 results_checked, words_sent, attempts_seen, anchored_seen, rolls_seen);
        $display("Input refused on %0d cycles; %0d field mismatches", input_stalls, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
